### design/gwsu_pkg.sv
// Shared constants and types for the toroidal grid word search unit.
`default_nettype none

package gwsu_pkg;

	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;
	localparam int DEF_MAX_WORD = 64;

	localparam int CFG_W    = 7;
	localparam int CFG_IDX_W = 1;
	localparam int SYM_W    = 8;
	localparam int POS_W    = 7;
	localparam int DIR_W    = 2;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd1;

	localparam logic KIND_GRID = 1'b0;
	localparam logic KIND_WORD = 1'b1;

	typedef enum logic [DIR_W-1:0] {
		DIR_UP    = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_RIGHT = 2'd3
	} dir_t;

endpackage

`default_nettype wire

### design/gwsu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gwsu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### design/toroidal_grid_word_search_unit.sv
// Top level of the toroidal grid word search unit.
// A grid item (kind 0) writes one byte into the grid memory in row-major order; a word
// item (kind 1) without the end mark stores one byte while room remains. A word item with
// the end mark starts a search over start cells (row by row, column by column) and
// directions (up, down, left, right) with wraparound; each compared character passes
// through the address, read and compare states on the shared address multiplier, grid
// memory read port and byte comparator. A word over MAX_WORD bytes reports not found with
// overflow set and takes no scan. A finished result waits in an output register, and the
// next item is accepted meanwhile.
`default_nettype none

module toroidal_grid_word_search_unit #(
	parameter int MAX_ROWS = gwsu_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = gwsu_pkg::DEF_MAX_COLS,
	parameter int MAX_WORD = gwsu_pkg::DEF_MAX_WORD
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wen,
	input  wire logic [gwsu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [gwsu_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           kind,
	input  wire logic [gwsu_pkg::SYM_W-1:0]     symbol,
	input  wire logic                           word_end,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                found,
	output logic [gwsu_pkg::DIR_W-1:0]          direction,
	output logic [gwsu_pkg::POS_W-1:0]          start_row,
	output logic [gwsu_pkg::POS_W-1:0]          start_col,
	output logic                                overflow
);

	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int AW    = CELLS > 1 ? $clog2(CELLS) : 1;
	localparam int TW    = $clog2(CELLS + 1);
	localparam int RW    = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
	localparam int RCW   = $clog2(MAX_ROWS + 1);
	localparam int CCW   = $clog2(MAX_COLS + 1);
	localparam int WIW   = MAX_WORD > 1 ? $clog2(MAX_WORD) : 1;
	localparam int WLW   = $clog2(MAX_WORD + 1);
	localparam int PW    = RW + CCW;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_ADDR,
		ST_RD,
		ST_CMP,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [gwsu_pkg::CFG_W-1:0] rows_q, cols_q;
	logic [RCW-1:0]             rows_eff;
	logic [CCW-1:0]             cols_eff;
	logic [RW-1:0]              last_row;
	logic [CW-1:0]              last_col;
	logic [TW-1:0]              total_q;

	logic                       kind_q, wend_q;
	logic [gwsu_pkg::SYM_W-1:0] sym_q;

	logic [AW-1:0]  lp_q;
	logic [AW-1:0]  load_addr;
	logic [TW-1:0]  load_next;

	logic [WLW-1:0] wlen_q;
	logic           too_long_q;
	logic           word_room;

	logic [RW-1:0]      r_q, cr_q;
	logic [CW-1:0]      c_q, cc_q;
	gwsu_pkg::dir_t     d_q;
	logic [WLW-1:0]     k_q;
	logic [PW-1:0]      prod;
	logic [AW-1:0]      prod_q;
	logic               res_found_q, res_ovf_q;

	logic                       grid_we, grid_re, word_we, word_re;
	logic [AW-1:0]              grid_waddr, grid_raddr;
	logic [gwsu_pkg::SYM_W-1:0] grid_rdata, word_rdata;

	logic                       out_valid_q, found_q, ovf_q;
	logic [gwsu_pkg::DIR_W-1:0] dir_q;
	logic [gwsu_pkg::POS_W-1:0] row_out_q, col_out_q;

	always_comb begin
		rows_eff = (rows_q == '0) ? RCW'(1)
			: ((32'(rows_q) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(rows_q));
		cols_eff = (cols_q == '0) ? CCW'(1)
			: ((32'(cols_q) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cols_q));
		last_row = RW'(rows_eff - RCW'(1));
		last_col = CW'(cols_eff - CCW'(1));
		load_addr = (TW'(lp_q) >= total_q) ? '0 : lp_q;
		load_next = TW'(load_addr) + TW'(1);
		word_room = (wlen_q < WLW'(MAX_WORD));
		prod = PW'(cr_q) * PW'(cols_eff);
		grid_raddr = prod_q + AW'(cc_q);
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign grid_we   = (state_q == ST_EXEC) && (kind_q == gwsu_pkg::KIND_GRID);
	assign grid_waddr = load_addr;
	assign grid_re   = (state_q == ST_RD);
	assign word_we   = (state_q == ST_EXEC) && (kind_q == gwsu_pkg::KIND_WORD) && word_room;
	assign word_re   = (state_q == ST_ADDR);

	gwsu_ram #(
		.WIDTH(gwsu_pkg::SYM_W),
		.DEPTH(CELLS)
	) u_grid_ram (
		.clk  (clk),
		.we   (grid_we),
		.waddr(grid_waddr),
		.wdata(sym_q),
		.re   (grid_re),
		.raddr(grid_raddr),
		.rdata(grid_rdata)
	);

	gwsu_ram #(
		.WIDTH(gwsu_pkg::SYM_W),
		.DEPTH(MAX_WORD)
	) u_word_ram (
		.clk  (clk),
		.we   (word_we),
		.waddr(wlen_q[WIW-1:0]),
		.wdata(sym_q),
		.re   (word_re),
		.raddr(k_q[WIW-1:0]),
		.rdata(word_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= gwsu_pkg::CFG_W'(1);
			cols_q  <= gwsu_pkg::CFG_W'(1);
			total_q <= TW'(1);
		end else begin
			total_q <= TW'(rows_eff * cols_eff);
			if (cfg_wen) begin
				case (cfg_index)
					gwsu_pkg::REG_GRID_ROWS: rows_q <= cfg_data;
					gwsu_pkg::REG_GRID_COLS: cols_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ADDR) begin
			prod_q <= prod[AW-1:0];
		end
		if (in_valid && in_ready) begin
			kind_q <= kind;
			sym_q  <= symbol;
			wend_q <= word_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lp_q        <= '0;
			wlen_q      <= '0;
			too_long_q  <= 1'b0;
			r_q         <= '0;
			c_q         <= '0;
			cr_q        <= '0;
			cc_q        <= '0;
			d_q         <= gwsu_pkg::DIR_UP;
			k_q         <= '0;
			res_found_q <= 1'b0;
			res_ovf_q   <= 1'b0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			ovf_q       <= 1'b0;
			dir_q       <= '0;
			row_out_q   <= '0;
			col_out_q   <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (kind_q == gwsu_pkg::KIND_GRID) begin
						lp_q    <= (load_next >= total_q) ? '0 : AW'(load_next);
						state_q <= ST_IDLE;
					end else begin
						if (word_room) begin
							wlen_q <= wlen_q + WLW'(1);
						end else begin
							too_long_q <= 1'b1;
						end
						if (!wend_q) begin
							state_q <= ST_IDLE;
						end else if (too_long_q || !word_room) begin
							res_found_q <= 1'b0;
							res_ovf_q   <= 1'b1;
							state_q     <= ST_EMIT;
						end else begin
							res_ovf_q <= 1'b0;
							r_q       <= '0;
							c_q       <= '0;
							cr_q      <= '0;
							cc_q      <= '0;
							d_q       <= gwsu_pkg::DIR_UP;
							k_q       <= '0;
							state_q   <= ST_ADDR;
						end
					end
				end
				ST_ADDR: begin
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (grid_rdata == word_rdata) begin
						if (k_q + WLW'(1) == wlen_q) begin
							res_found_q <= 1'b1;
							state_q     <= ST_EMIT;
						end else begin
							k_q <= k_q + WLW'(1);
							case (d_q)
								gwsu_pkg::DIR_UP:
									cr_q <= (cr_q == '0) ? last_row : cr_q - RW'(1);
								gwsu_pkg::DIR_DOWN:
									cr_q <= (cr_q == last_row) ? '0 : cr_q + RW'(1);
								gwsu_pkg::DIR_LEFT:
									cc_q <= (cc_q == '0) ? last_col : cc_q - CW'(1);
								default:
									cc_q <= (cc_q == last_col) ? '0 : cc_q + CW'(1);
							endcase
							state_q <= ST_ADDR;
						end
					end else begin
						k_q <= '0;
						if (d_q != gwsu_pkg::DIR_RIGHT) begin
							d_q     <= gwsu_pkg::dir_t'(d_q + gwsu_pkg::DIR_W'(1));
							cr_q    <= r_q;
							cc_q    <= c_q;
							state_q <= ST_ADDR;
						end else begin
							d_q <= gwsu_pkg::DIR_UP;
							if (c_q != last_col) begin
								c_q     <= c_q + CW'(1);
								cc_q    <= c_q + CW'(1);
								cr_q    <= r_q;
								state_q <= ST_ADDR;
							end else if (r_q != last_row) begin
								r_q     <= r_q + RW'(1);
								cr_q    <= r_q + RW'(1);
								c_q     <= '0;
								cc_q    <= '0;
								state_q <= ST_ADDR;
							end else begin
								res_found_q <= 1'b0;
								state_q     <= ST_EMIT;
							end
						end
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						found_q     <= res_found_q;
						ovf_q       <= res_ovf_q;
						dir_q       <= res_found_q ? d_q : gwsu_pkg::DIR_UP;
						row_out_q   <= res_found_q
							? gwsu_pkg::POS_W'({1'b0, r_q} + 1'b1) : '0;
						col_out_q   <= res_found_q
							? gwsu_pkg::POS_W'({1'b0, c_q} + 1'b1) : '0;
						wlen_q      <= '0;
						too_long_q  <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign direction = dir_q;
	assign start_row = row_out_q;
	assign start_col = col_out_q;
	assign overflow  = ovf_q;

endmodule

`default_nettype wire
